>>> rtl/core/twas_pkg.sv
// Shared types, constants and helper functions for the time window actuator scheduler.
package twas_pkg;

  localparam int PROGRAM_SLOTS = 16;
  localparam int PTR_W = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
  localparam int TOT_W = $clog2(PROGRAM_SLOTS + 1);

  localparam int MIN_W = 11;
  localparam int LVL_W = 10;
  localparam int CMD_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int LOADED_W = 5;

  localparam logic [LVL_W-1:0] REFILL_RESET = LVL_W'(820);
  localparam logic [LVL_W-1:0] FAULT_RESET = LVL_W'(50);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 4'd0,
    CMD_FEED_ON     = 4'd1,
    CMD_FEED_OFF    = 4'd2,
    CMD_WATER_ON    = 4'd3,
    CMD_WATER_OFF   = 4'd4,
    CMD_LAMP_ON     = 4'd5,
    CMD_LAMP_OFF    = 4'd6,
    CMD_WATER_STOP  = 4'd7,
    CMD_FEED_STOP   = 4'd8,
    CMD_LOAD_BEGIN  = 4'd9,
    CMD_LOAD_ENTRY  = 4'd10,
    CMD_LOAD_END    = 4'd11,
    CMD_STATUS      = 4'd12
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMP_START = 3'd0,
    CFG_LAMP_END   = 3'd1,
    CFG_LAMP_SCHED = 3'd2,
    CFG_REFILL_THR = 3'd3,
    CFG_FAULT_THR  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [MIN_W-1:0] start_min;
    logic [MIN_W-1:0] end_min;
    logic             enabled;
    logic             is_water;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic apply;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
  } dp_status_t;

  // [s, e) window; wraps past midnight when e < s, never active when s == e
  function automatic logic in_window(logic [MIN_W-1:0] m, logic [MIN_W-1:0] s,
                                     logic [MIN_W-1:0] e);
    if (e < s) begin
      return (m >= s) || (m < e);
    end
    return (m >= s) && (m < e);
  endfunction

endpackage

>>> rtl/core/time_window_actuator_scheduler.sv
// Top level of the time window actuator scheduler: controller plus datapath.
//
// Input channel (in_valid/in_ready): one beat carries a command with its tick
// fields (minute of day, raw level) and its load-entry fields. Output channel
// (out_valid/out_ready): exactly one result beat per input beat, holding the
// actuator and status flags after that command.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 lamp start, 1 lamp end, 2 lamp schedule enable, 3 refill threshold,
// 4 sensor fault threshold; other indexes are dropped). Write only when idle.
// Sequence: a command is accepted in S_IDLE and passes S_SCAN, S_APPLY and
// S_EMIT in turn; a tick over N loaded entries (at most 16) stays in S_SCAN
// while the scan reads the program table one entry per cycle
// through its single registered read port. A new beat is taken the cycle
// after the result is loaded, so items are worked on one at a time.
// A result that the receiver stalls sits in the output register; the next
// item is still accepted and worked on, and waits only to load its result.
// Reset (rst, synchronous): table empty, actuators and overrides off, both
// program kinds allowed, thresholds 820 / 50, lamp schedule off. Table
// contents need no clearing; only entries below the loaded count are read.
module time_window_actuator_scheduler
  import twas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [MIN_W-1:0]      minute_of_day,
  input  logic [LVL_W-1:0]      level_raw,
  input  logic [MIN_W-1:0]      entry_start_minute,
  input  logic [MIN_W-1:0]      entry_end_minute,
  input  logic                  entry_enabled,
  input  logic                  entry_is_water,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  feeding_active,
  output logic                  water_active,
  output logic                  refill_active,
  output logic                  lamp_active,
  output logic                  indicator_led,
  output logic                  feed_programs_on,
  output logic                  water_programs_on,
  output logic [LOADED_W-1:0]   programs_loaded
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: accept, scan (ticks only), update, result beat
  twas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // table, window compare, actuator state and result register
  twas_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .command            (command),
    .minute_of_day      (minute_of_day),
    .level_raw          (level_raw),
    .entry_start_minute (entry_start_minute),
    .entry_end_minute   (entry_end_minute),
    .entry_enabled      (entry_enabled),
    .entry_is_water     (entry_is_water),
    .feeding_active     (feeding_active),
    .water_active       (water_active),
    .refill_active      (refill_active),
    .lamp_active        (lamp_active),
    .indicator_led      (indicator_led),
    .feed_programs_on   (feed_programs_on),
    .water_programs_on  (water_programs_on),
    .programs_loaded    (programs_loaded)
  );

endmodule

>>> rtl/core/twas_ctrl.sv
// Sequencer for the scheduler: capture, table scan, state update, result beat.
module twas_ctrl
  import twas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_slot_free;

  assign in_ready      = (state == S_IDLE);
  assign out_slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!status.is_tick || status.scan_done) begin
          state_next = S_APPLY;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/twas_dp.sv
// Datapath: config registers, program table, scan, actuator state, result register.
module twas_dp
  import twas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      command,
  input  logic [MIN_W-1:0]      minute_of_day,
  input  logic [LVL_W-1:0]      level_raw,
  input  logic [MIN_W-1:0]      entry_start_minute,
  input  logic [MIN_W-1:0]      entry_end_minute,
  input  logic                  entry_enabled,
  input  logic                  entry_is_water,
  output logic                  feeding_active,
  output logic                  water_active,
  output logic                  refill_active,
  output logic                  lamp_active,
  output logic                  indicator_led,
  output logic                  feed_programs_on,
  output logic                  water_programs_on,
  output logic [LOADED_W-1:0]   programs_loaded
);

  // configuration
  logic [MIN_W-1:0] lamp_start;
  logic [MIN_W-1:0] lamp_end;
  logic             lamp_sched;
  logic [LVL_W-1:0] refill_thr;
  logic [LVL_W-1:0] fault_thr;

  // captured item
  cmd_t             cmd_r;
  logic [MIN_W-1:0] minute;
  logic [LVL_W-1:0] level;
  entry_t           entry_in;

  // program table
  entry_t           table_mem [PROGRAM_SLOTS];
  entry_t           rd_data;
  logic             rd_vld;
  logic [TOT_W-1:0] scan_idx;
  logic             any_feed;
  logic             any_water;
  logic             wr_en;

  // actuator state
  logic [TOT_W-1:0] total;
  logic             feeder_on, pump_on, refill_on, lamp_on, led_on;
  logic             feeder_ovr, pump_ovr, lamp_ovr;
  logic             feed_allow, water_allow;

  logic [TOT_W-1:0] total_next;
  logic             feeder_on_next, pump_on_next, refill_on_next, lamp_on_next;
  logic             led_on_next, feeder_ovr_next, pump_ovr_next, lamp_ovr_next;
  logic             feed_allow_next, water_allow_next;
  logic             lamp_want;
  logic             rd_hit;

  assign status.is_tick   = (cmd_r == CMD_TICK);
  assign status.scan_done = (scan_idx == total) && !rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_start <= '0;
      lamp_end   <= '0;
      lamp_sched <= 1'b0;
      refill_thr <= REFILL_RESET;
      fault_thr  <= FAULT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LAMP_START: lamp_start <= cfg_data[MIN_W-1:0];
        CFG_LAMP_END:   lamp_end   <= cfg_data[MIN_W-1:0];
        CFG_LAMP_SCHED: lamp_sched <= cfg_data[0];
        CFG_REFILL_THR: refill_thr <= cfg_data[LVL_W-1:0];
        CFG_FAULT_THR:  fault_thr  <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r              <= cmd_t'(command);
      minute             <= minute_of_day;
      level              <= level_raw;
      entry_in.start_min <= entry_start_minute;
      entry_in.end_min   <= entry_end_minute;
      entry_in.enabled   <= entry_enabled;
      entry_in.is_water  <= entry_is_water;
    end
  end

  // scan: one entry read per cycle, evaluated the cycle after
  assign rd_hit = rd_data.enabled
                  && (rd_data.is_water ? water_allow : feed_allow)
                  && in_window(minute, rd_data.start_min, rd_data.end_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else if (cmd.capture) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else if (cmd.scan_en && (scan_idx < total)) begin
      scan_idx <= scan_idx + TOT_W'(1);
      rd_vld   <= 1'b1;
    end else begin
      rd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      any_feed  <= 1'b0;
      any_water <= 1'b0;
    end else if (rd_vld && rd_hit) begin
      if (rd_data.is_water) begin
        any_water <= 1'b1;
      end else begin
        any_feed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && (scan_idx < total)) begin
      rd_data <= table_mem[scan_idx[PTR_W-1:0]];
    end
    if (wr_en) begin
      table_mem[total[PTR_W-1:0]] <= entry_in;
    end
  end

  assign lamp_want = in_window(minute, lamp_start, lamp_end);

  always_comb begin
    total_next       = total;
    feeder_on_next   = feeder_on;
    pump_on_next     = pump_on;
    refill_on_next   = refill_on;
    lamp_on_next     = lamp_on;
    led_on_next      = led_on;
    feeder_ovr_next  = feeder_ovr;
    pump_ovr_next    = pump_ovr;
    lamp_ovr_next    = lamp_ovr;
    feed_allow_next  = feed_allow;
    water_allow_next = water_allow;
    wr_en            = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        refill_on_next = (level < fault_thr) || (level > refill_thr);
        if (any_feed && !feeder_on) begin
          feeder_ovr_next = 1'b0;
          feeder_on_next  = 1'b1;
          led_on_next     = 1'b1;
        end else if (!any_feed && feeder_on && !feeder_ovr) begin
          feeder_on_next = 1'b0;
          led_on_next    = 1'b0;
        end
        if (any_water && !pump_on) begin
          pump_ovr_next = 1'b0;
          pump_on_next  = 1'b1;
          led_on_next   = 1'b1;
        end else if (!any_water && pump_on && !pump_ovr) begin
          pump_on_next = 1'b0;
          led_on_next  = 1'b0;
        end
        // a manual lamp-on holds against the schedule
        if (lamp_sched && !(lamp_ovr && lamp_on)) begin
          if (lamp_want && !lamp_on) begin
            lamp_on_next = 1'b1;
          end else if (!lamp_want && lamp_on && !lamp_ovr) begin
            lamp_on_next = 1'b0;
          end
        end
      end
      CMD_FEED_ON: begin
        feeder_on_next  = 1'b1;
        feeder_ovr_next = 1'b1;
        led_on_next     = 1'b1;
      end
      CMD_FEED_OFF: begin
        feeder_on_next  = 1'b0;
        feeder_ovr_next = 1'b0;
        led_on_next     = 1'b0;
      end
      CMD_WATER_ON: begin
        pump_on_next  = 1'b1;
        pump_ovr_next = 1'b1;
        led_on_next   = 1'b1;
      end
      CMD_WATER_OFF: begin
        pump_on_next  = 1'b0;
        pump_ovr_next = 1'b0;
        led_on_next   = 1'b0;
      end
      CMD_LAMP_ON: begin
        lamp_on_next  = 1'b1;
        lamp_ovr_next = 1'b1;
      end
      CMD_LAMP_OFF: begin
        lamp_on_next  = 1'b0;
        lamp_ovr_next = 1'b0;
      end
      CMD_WATER_STOP: begin
        pump_on_next     = 1'b0;
        pump_ovr_next    = 1'b0;
        water_allow_next = 1'b0;
        led_on_next      = 1'b0;
      end
      CMD_FEED_STOP: begin
        feeder_on_next  = 1'b0;
        feeder_ovr_next = 1'b0;
        feed_allow_next = 1'b0;
        led_on_next     = 1'b0;
      end
      CMD_LOAD_BEGIN: total_next = '0;
      CMD_LOAD_ENTRY: begin
        if (total < TOT_W'(PROGRAM_SLOTS)) begin
          wr_en      = cmd.apply;
          total_next = total + TOT_W'(1);
          if (entry_in.is_water) begin
            water_allow_next = 1'b1;
          end else begin
            feed_allow_next = 1'b1;
          end
        end
      end
      CMD_LOAD_END: begin
        feeder_on_next  = 1'b0;
        pump_on_next    = 1'b0;
        feeder_ovr_next = 1'b0;
        pump_ovr_next   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total       <= '0;
      feeder_on   <= 1'b0;
      pump_on     <= 1'b0;
      refill_on   <= 1'b0;
      lamp_on     <= 1'b0;
      led_on      <= 1'b0;
      feeder_ovr  <= 1'b0;
      pump_ovr    <= 1'b0;
      lamp_ovr    <= 1'b0;
      feed_allow  <= 1'b1;
      water_allow <= 1'b1;
    end else if (cmd.apply) begin
      total       <= total_next;
      feeder_on   <= feeder_on_next;
      pump_on     <= pump_on_next;
      refill_on   <= refill_on_next;
      lamp_on     <= lamp_on_next;
      led_on      <= led_on_next;
      feeder_ovr  <= feeder_ovr_next;
      pump_ovr    <= pump_ovr_next;
      lamp_ovr    <= lamp_ovr_next;
      feed_allow  <= feed_allow_next;
      water_allow <= water_allow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      feeding_active    <= feeder_on;
      water_active      <= pump_on;
      refill_active     <= refill_on;
      lamp_active       <= lamp_on;
      indicator_led     <= led_on;
      feed_programs_on  <= feed_allow;
      water_programs_on <= water_allow;
      programs_loaded   <= LOADED_W'(total);
    end
  end

endmodule
